@@ rtl/bbc_pkg.sv @@
// Shared types, codes and constants for the bracket balance checker.
`default_nettype none

package bbc_pkg;

    // Default number of stack entries.
    localparam int STACK_DEPTH_DEF = 64;

    // Entries in the queue between the classifier and the stack engine.
    localparam int QUEUE_DEPTH = 4;

    // Field widths on the streams.
    localparam int SYMBOL_W    = 8;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_OUT_W = 7;
    localparam int M_DATA_W    = 16;

    // Character codes of the brackets.
    localparam logic [SYMBOL_W-1:0] CHAR_OPEN_ROUND   = 8'h28;
    localparam logic [SYMBOL_W-1:0] CHAR_OPEN_SQUARE  = 8'h5B;
    localparam logic [SYMBOL_W-1:0] CHAR_OPEN_CURLY   = 8'h7B;
    localparam logic [SYMBOL_W-1:0] CHAR_CLOSE_ROUND  = 8'h29;
    localparam logic [SYMBOL_W-1:0] CHAR_CLOSE_SQUARE = 8'h5D;
    localparam logic [SYMBOL_W-1:0] CHAR_CLOSE_CURLY  = 8'h7D;

    // Bracket kind as kept on the stack.
    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2
    } kind_t;

    // What the stack engine has to do with one byte.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BALANCED   = 3'd1,
        ST_NO_OPEN    = 3'd2,
        ST_WRONG_KIND = 3'd3,
        ST_UNCLOSED   = 3'd4,
        ST_OVERFLOW   = 3'd5
    } status_t;

    // Classified byte handed from the front end to the stack engine.
    typedef struct packed {
        op_t   op;
        kind_t kind;
        logic  last;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/bbc_front.sv @@
// Front end: accepts input beats and classifies each byte as open, close or other.
`default_nettype none

module bbc_front
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [bbc_pkg::SYMBOL_W-1:0]      s_tdata,   // [7:0] symbol
    input  wire                               s_tlast,
    output logic                              cmd_valid,
    input  wire                               cmd_ready,
    output bbc_pkg::cmd_t                     cmd
);

    logic seen_beat_reg;
    logic seen_beat_next;

    // Handshake passes straight into the queue; the queue sets the pace.
    assign cmd_valid = s_tvalid;
    assign s_tready  = cmd_ready;

    // Decode the byte into an operation and a bracket kind.
    always_comb
    begin
        cmd.last = s_tlast;
        case (s_tdata)
            bbc_pkg::CHAR_OPEN_ROUND:
            begin
                cmd.op   = bbc_pkg::OP_OPEN;
                cmd.kind = bbc_pkg::KIND_ROUND;
            end
            bbc_pkg::CHAR_OPEN_SQUARE:
            begin
                cmd.op   = bbc_pkg::OP_OPEN;
                cmd.kind = bbc_pkg::KIND_SQUARE;
            end
            bbc_pkg::CHAR_OPEN_CURLY:
            begin
                cmd.op   = bbc_pkg::OP_OPEN;
                cmd.kind = bbc_pkg::KIND_CURLY;
            end
            bbc_pkg::CHAR_CLOSE_ROUND:
            begin
                cmd.op   = bbc_pkg::OP_CLOSE;
                cmd.kind = bbc_pkg::KIND_ROUND;
            end
            bbc_pkg::CHAR_CLOSE_SQUARE:
            begin
                cmd.op   = bbc_pkg::OP_CLOSE;
                cmd.kind = bbc_pkg::KIND_SQUARE;
            end
            bbc_pkg::CHAR_CLOSE_CURLY:
            begin
                cmd.op   = bbc_pkg::OP_CLOSE;
                cmd.kind = bbc_pkg::KIND_CURLY;
            end
            default:
            begin
                cmd.op   = bbc_pkg::OP_NONE;
                cmd.kind = bbc_pkg::KIND_ROUND;
            end
        endcase
    end

    // Track whether any beat has arrived since reset, for the checks below.
    assign seen_beat_next = seen_beat_reg | (s_tvalid & s_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_beat_reg <= 1'b0;
        end
        else
        begin
            seen_beat_reg <= seen_beat_next;
        end
    end

    // A bracket byte must never be classified as a plain byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && (s_tdata == bbc_pkg::CHAR_OPEN_ROUND ||
                      s_tdata == bbc_pkg::CHAR_OPEN_SQUARE ||
                      s_tdata == bbc_pkg::CHAR_OPEN_CURLY)) |-> (cmd.op == bbc_pkg::OP_OPEN))
        else $error("Opening bracket not decoded as a push.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && (s_tdata == bbc_pkg::CHAR_CLOSE_ROUND ||
                      s_tdata == bbc_pkg::CHAR_CLOSE_SQUARE ||
                      s_tdata == bbc_pkg::CHAR_CLOSE_CURLY)) |-> (cmd.op == bbc_pkg::OP_CLOSE))
        else $error("Closing bracket not decoded as a pop.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> seen_beat_reg)
        else $error("Accepted beat was not recorded.");

endmodule

`default_nettype wire

@@ rtl/bbc_queue.sv @@
// Short command queue that decouples the classifier from the stack engine.
`default_nettype none

module bbc_queue
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    input  bbc_pkg::cmd_t  in_cmd,
    output logic           out_valid,
    input  wire            out_ready,
    output bbc_pkg::cmd_t  out_cmd
);

    localparam int PTR_W  = (bbc_pkg::QUEUE_DEPTH > 1) ? $clog2(bbc_pkg::QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(bbc_pkg::QUEUE_DEPTH + 1);

    bbc_pkg::cmd_t     entry_reg [bbc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              push;
    logic              pop;

    assign in_ready  = (fill_reg != FILL_W'(bbc_pkg::QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];

    assign push = in_valid & in_ready;
    assign pop  = out_valid & out_ready;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(bbc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(bbc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bbc_back.sv @@
// Stack engine: runs push and pop on the kind stack and registers one result per byte.
`default_nettype none

module bbc_back
#(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
)
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cmd_valid,
    output logic                               cmd_ready,
    input  bbc_pkg::cmd_t                      cmd,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [bbc_pkg::M_DATA_W-1:0]       m_tdata    // [2:0] status, [9:3] open_depth
);

    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int PAD_W     = bbc_pkg::M_DATA_W - bbc_pkg::STATUS_W - bbc_pkg::DEPTH_OUT_W;

    // Stack storage; the top entry is also kept here, besides its cached copy.
    bbc_pkg::kind_t stack_mem [MEM_DEPTH];

    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [CNT_W-1:0]                  count_after;
    bbc_pkg::status_t                  err_reg;
    bbc_pkg::status_t                  err_next;
    bbc_pkg::status_t                  err_after;
    bbc_pkg::kind_t                    top_reg;
    bbc_pkg::kind_t                    top_next;
    bbc_pkg::kind_t                    below_reg;
    logic [CNT_W:0]                    rd_sum;
    logic [ADDR_W-1:0]                 rd_addr;
    logic                              do_push;
    logic                              do_pop;
    logic                              go;
    bbc_pkg::status_t                  status_next;
    logic                              out_valid_reg;
    bbc_pkg::status_t                  out_status_reg;
    logic [bbc_pkg::DEPTH_OUT_W-1:0]   out_depth_reg;

    // The result register frees up when it is empty or being taken.
    assign cmd_ready = !out_valid_reg || m_tready;
    assign go        = cmd_valid && cmd_ready;

    // Stack operation and error detection for the byte at the queue head.
    always_comb
    begin
        count_next = count_reg;
        err_next   = err_reg;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        if (err_reg == bbc_pkg::ST_OK)
        begin
            case (cmd.op)
                bbc_pkg::OP_OPEN:
                begin
                    if (count_reg == CNT_W'(STACK_DEPTH))
                    begin
                        err_next = bbc_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        do_push    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                bbc_pkg::OP_CLOSE:
                begin
                    if (count_reg == '0)
                    begin
                        err_next = bbc_pkg::ST_NO_OPEN;
                    end
                    else if (top_reg != cmd.kind)
                    begin
                        err_next = bbc_pkg::ST_WRONG_KIND;
                    end
                    else
                    begin
                        do_pop     = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Status of this byte, including the verdict on the final byte.
    always_comb
    begin
        if (cmd.last && err_next == bbc_pkg::ST_OK)
        begin
            status_next = (count_next == '0) ? bbc_pkg::ST_BALANCED : bbc_pkg::ST_UNCLOSED;
        end
        else
        begin
            status_next = err_next;
        end
    end

    // New top of stack: the pushed kind, or the entry below after a pop.
    always_comb
    begin
        if (do_push)
        begin
            top_next = cmd.kind;
        end
        else if (do_pop)
        begin
            top_next = below_reg;
        end
        else
        begin
            top_next = top_reg;
        end
    end

    // State after this cycle, with the clear on the final byte.
    assign count_after = go ? (cmd.last ? '0 : count_next) : count_reg;
    assign err_after   = go ? (cmd.last ? bbc_pkg::ST_OK : err_next) : err_reg;

    // Prefetch the entry below the new top so a pop can follow every cycle.
    assign rd_sum  = {1'b0, count_after} - (CNT_W + 1)'(2);
    assign rd_addr = rd_sum[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (go && do_push)
        begin
            stack_mem[count_reg[ADDR_W-1:0]] <= cmd.kind;
        end
        below_reg <= stack_mem[rd_addr];
    end

    // Stack control state and cached top.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            err_reg   <= bbc_pkg::ST_OK;
        end
        else
        begin
            count_reg <= count_after;
            err_reg   <= err_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            top_reg <= top_next;
        end
    end

    // Result register toward the output stream.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            out_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            out_status_reg <= status_next;
            out_depth_reg  <= bbc_pkg::DEPTH_OUT_W'(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_depth_reg, out_status_reg};

    // The stack never holds more entries than it has.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("Stack count beyond depth.");

    // Once an error is latched, later bytes of the string leave the state alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (go && err_reg != bbc_pkg::ST_OK && !cmd.last) |=>
        (count_reg == $past(count_reg) && err_reg == $past(err_reg)))
        else $error("Sticky error did not freeze the stack.");

    // The final byte of a string leaves a clean state behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (go && cmd.last) |=> (count_reg == '0 && err_reg == bbc_pkg::ST_OK))
        else $error("State not cleared after final byte.");

endmodule

`default_nettype wire

@@ rtl/bracket_balance_checker.sv @@
// Top level of the bracket balance checker: front end, command queue and stack engine.
//
//  Channel   Dir   Beat fields (low bit first)          Accepted when
//  s_*       in    tdata[7:0] symbol, tlast = last       s_tvalid && s_tready
//  m_*       out   tdata[2:0] status, [9:3] open_depth   m_tvalid && m_tready
//
// One byte per cycle is sustained while the output is ready; each byte gives one result
// beat, registered first in the queue and then in the stack engine's result register.
// The cached top of stack plus a prefetched entry below it let pops and pushes
// follow each other every cycle from a stack memory with one write and one read port.
// Reset clears the counts, the error state and the queue; the stack memory
// needs no clearing pass.
// A stalled output holds the result register; the queue then absorbs up to
// four more bytes before the input stalls.
`default_nettype none

module bracket_balance_checker
#(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [bbc_pkg::SYMBOL_W-1:0]     s_tdata,   // [7:0] symbol
    input  wire                              s_tlast,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [bbc_pkg::M_DATA_W-1:0]     m_tdata    // [2:0] status, [9:3] open_depth
);

    logic          front_valid;
    logic          front_ready;
    bbc_pkg::cmd_t front_cmd;
    logic          back_valid;
    logic          back_ready;
    bbc_pkg::cmd_t back_cmd;

    // Classify incoming bytes.
    bbc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // Decouple front end from stack engine.
    bbc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    // Run the stack and produce results.
    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

@@ sim/bbc_stream_checker.sv @@
// Stream checker for the bracket balance checker: predicts each result beat and compares it.
`timescale 1ns / 1ps

module bbc_stream_checker
#(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [bbc_pkg::SYMBOL_W-1:0] s_tdata,   // [7:0] symbol
    input  logic                         s_tlast,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [bbc_pkg::M_DATA_W-1:0] m_tdata,   // [2:0] status, [9:3] open_depth
    output int                           mismatches,
    output int                           outstanding
);

    import bbc_pkg::*;

    localparam int PAD_LO = STATUS_W + DEPTH_OUT_W;

    // One predicted result beat.
    typedef struct packed {
        status_t                status;
        logic [DEPTH_OUT_W-1:0] depth;
    } verdict_t;

    // Shadow copy of the bracket stack and the per-string error state.
    kind_t    kind_mem [STACK_DEPTH];
    int       open_cnt;
    status_t  first_err;
    verdict_t verdict_q[$];

    // Apply one byte to the shadow stack and work out the verdict it produces.
    task automatic score_symbol(input logic [SYMBOL_W-1:0] ch, input logic fin,
                                output verdict_t v);
        op_t   op;
        kind_t k;
        op = OP_NONE;
        k  = KIND_ROUND;
        case (ch)
            CHAR_OPEN_ROUND:   begin op = OP_OPEN;  k = KIND_ROUND;  end
            CHAR_OPEN_SQUARE:  begin op = OP_OPEN;  k = KIND_SQUARE; end
            CHAR_OPEN_CURLY:   begin op = OP_OPEN;  k = KIND_CURLY;  end
            CHAR_CLOSE_ROUND:  begin op = OP_CLOSE; k = KIND_ROUND;  end
            CHAR_CLOSE_SQUARE: begin op = OP_CLOSE; k = KIND_SQUARE; end
            CHAR_CLOSE_CURLY:  begin op = OP_CLOSE; k = KIND_CURLY;  end
            default:           op = OP_NONE;
        endcase

        // Once an error is latched, the rest of the string leaves everything alone.
        if (first_err == ST_OK)
        begin
            if (op == OP_OPEN)
            begin
                if (open_cnt >= STACK_DEPTH)
                    first_err = ST_OVERFLOW;
                else
                begin
                    kind_mem[open_cnt] = k;
                    open_cnt++;
                end
            end
            else if (op == OP_CLOSE)
            begin
                if (open_cnt == 0)
                    first_err = ST_NO_OPEN;
                else if (kind_mem[open_cnt-1] != k)
                    first_err = ST_WRONG_KIND;
                else
                    open_cnt--;
            end
        end

        // The final byte turns a clean string into balanced or unclosed.
        if (!fin || first_err != ST_OK)
            v.status = first_err;
        else if (open_cnt == 0)
            v.status = ST_BALANCED;
        else
            v.status = ST_UNCLOSED;
        v.depth = open_cnt[DEPTH_OUT_W-1:0];

        if (fin)
        begin
            open_cnt  = 0;
            first_err = ST_OK;
        end
    endtask

    // Predict on every input beat and compare every output beat with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t v;
        int       bad;
        if (!rst_n)
        begin
            open_cnt  = 0;
            first_err = ST_OK;
            verdict_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            bad = 0;
            if (s_tvalid && s_tready)
            begin
                score_symbol(s_tdata, s_tlast, v);
                verdict_q.push_back(v);
            end
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, m_tdata);
                    bad++;
                end
                else
                begin
                    v = verdict_q.pop_front();
                    if (m_tdata[STATUS_W-1:0] !== v.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, v.status, m_tdata[STATUS_W-1:0]);
                        bad++;
                    end
                    if (m_tdata[STATUS_W +: DEPTH_OUT_W] !== v.depth)
                    begin
                        $display("%0t: open_depth mismatch, expected %0d, actual %0d",
                                 $time, v.depth, m_tdata[STATUS_W +: DEPTH_OUT_W]);
                        bad++;
                    end
                    if (m_tdata[M_DATA_W-1:PAD_LO] !== '0)
                    begin
                        $display("%0t: padding mismatch, expected 0, actual %h",
                                 $time, m_tdata[M_DATA_W-1:PAD_LO]);
                        bad++;
                    end
                end
            end
            mismatches  <= mismatches + bad;
            outstanding <= verdict_q.size();
        end
    end

endmodule

@@ sim/tb_bracket_balance_checker.sv @@
// Testbench top for the bracket balance checker: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_bracket_balance_checker;

    import bbc_pkg::*;

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int ITEM_TARGET = 1900;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 20;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SYMBOL_W-1:0] s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;

    // Flow control knobs.
    int   send_idle  = 13;
    int   recv_idle  = 49;
    logic hold_req   = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;
    int   quiet      = 0;

    // Bytes of the string being built, and the count of bytes sent so far.
    logic [SYMBOL_W-1:0] text_q[$];
    int                  sent = 0;

    always #4 clk = ~clk;

    bracket_balance_checker #(.STACK_DEPTH(STACK_DEPTH)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bbc_stream_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Receiver: random back-pressure, plus one long hold-off once it is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (rst_n && hold_req && !hold_taken)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle);
    end

    // Watchdog: too many cycles in a row without any beat on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [SYMBOL_W-1:0] open_char(input int k);
        case (k)
            0:       return CHAR_OPEN_ROUND;
            1:       return CHAR_OPEN_SQUARE;
            default: return CHAR_OPEN_CURLY;
        endcase
    endfunction

    function automatic logic [SYMBOL_W-1:0] close_char(input int k);
        case (k)
            0:       return CHAR_CLOSE_ROUND;
            1:       return CHAR_CLOSE_SQUARE;
            default: return CHAR_CLOSE_CURLY;
        endcase
    endfunction

    // Any byte that is not a bracket; all bracket codes sit below 8'h80.
    function automatic logic [SYMBOL_W-1:0] noise_char();
        logic [SYMBOL_W-1:0] ch;
        ch = SYMBOL_W'($urandom_range(0, 255));
        case (ch)
            CHAR_OPEN_ROUND, CHAR_OPEN_SQUARE, CHAR_OPEN_CURLY,
            CHAR_CLOSE_ROUND, CHAR_CLOSE_SQUARE, CHAR_CLOSE_CURLY:
                ch = ch ^ 8'h80;
            default: ;
        endcase
        return ch;
    endfunction

    // Offer one beat, with random idle cycles ahead of it, and wait until it is taken.
    task automatic send_beat(input logic [SYMBOL_W-1:0] ch, input logic fin);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Send the built string with tlast on its final byte, then clear the buffer.
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_beat(text_q[i], i == text_q.size() - 1);
        sent += text_q.size();
        text_q.delete();
    endtask

    task automatic push_string(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
        send_text();
    endtask

    // Well-formed nesting with random kinds and interleaved noise bytes.
    task automatic build_nested(input int n_open, input int noise_pct);
        int kinds [STACK_DEPTH];
        int depth;
        int left;
        int k;
        depth = 0;
        left  = n_open;
        while (left > 0 || depth > 0)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                text_q.push_back(noise_char());
            if (left > 0 && (depth == 0 || (depth < STACK_DEPTH && $urandom_range(0, 1))))
            begin
                k = $urandom_range(0, 2);
                kinds[depth] = k;
                depth++;
                left--;
                text_q.push_back(open_char(k));
            end
            else
            begin
                depth--;
                text_q.push_back(close_char(kinds[depth]));
            end
        end
    endtask

    // Runs of openers around the stack limit, closed in reverse order.
    task automatic build_deep();
        int kinds [STACK_DEPTH + 8];
        int n;
        n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
        for (int i = 0; i < n; i++)
        begin
            kinds[i] = $urandom_range(0, 2);
            text_q.push_back(open_char(kinds[i]));
        end
        for (int i = n - 1; i >= 0; i--)
            text_q.push_back(close_char(kinds[i]));
    endtask

    // Short strings that are mostly brackets in random order.
    task automatic build_broken();
        int n;
        n = $urandom_range(1, 16);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 60)
            begin
                if ($urandom_range(0, 1))
                    text_q.push_back(open_char($urandom_range(0, 2)));
                else
                    text_q.push_back(close_char($urandom_range(0, 2)));
            end
            else
                text_q.push_back(SYMBOL_W'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin : stimulus
        int r;
        int pos;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings: balanced nesting, the no-open and wrong-kind errors, unclosed, plain bytes.
        push_string("([{}])");
        push_string(")");
        push_string("(]x");
        push_string("[)");
        push_string("((");
        push_string("}}");
        push_string("{]");
        text_q.push_back(8'h00);
        send_text();
        text_q.push_back(8'hFF);
        send_text();

        // Random strings through three flow-control phases.
        while (sent < ITEM_TARGET)
        begin
            if (sent < ITEM_TARGET / 3)
            begin
                send_idle = 13;
                recv_idle <= 49;
            end
            else if (sent < 2 * ITEM_TARGET / 3)
            begin
                send_idle = 49;
                recv_idle <= 13;
            end
            else
            begin
                send_idle = 0;
                recv_idle <= 0;
                hold_req  <= 1'b1;
            end

            r = $urandom_range(0, 99);
            if (r < 3)
                build_deep();
            else if (r < 75)
            begin
                build_nested($urandom_range(0, 12), 20);
                // Now and then damage a clean string or cut it short.
                if (text_q.size() > 0 && $urandom_range(0, 99) < 12)
                begin
                    pos = $urandom_range(0, text_q.size() - 1);
                    text_q[pos] = $urandom_range(0, 1) ? open_char($urandom_range(0, 2))
                                                       : close_char($urandom_range(0, 2));
                end
                else if (text_q.size() > 2 && $urandom_range(0, 99) < 10)
                    text_q = text_q[0:text_q.size() - 2];
            end
            else
                build_broken();
            if (text_q.size() == 0)
                text_q.push_back(noise_char());
            send_text();
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        // Drain the results still in flight, then allow a little more for strays.
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
